// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler.
// Holds operation codes, task modes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;
    localparam int DEF_NUM_TASKS      = 16;
    localparam int DEF_NUM_PRIORITIES = 32;
    localparam int TID_W              = 4;
    localparam int PRI_W              = 5;
    localparam int TICK_W             = 32;

    localparam logic [1:0] OP_MAKE_READY = 2'd0;
    localparam logic [1:0] OP_DELAY      = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;
    localparam logic [1:0] OP_SCHEDULE   = 2'd3;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_READY   = 2'd1;
    localparam logic [1:0] MODE_DELAYED = 2'd2;
    localparam logic [1:0] MODE_RUNNING = 2'd3;

    // Shared compare unit request and answer.
    typedef struct packed {
        logic [TICK_W-1:0] a;
        logic [TICK_W-1:0] b;
    } cmp_req_t;

    typedef struct packed {
        logic later;   // a - b positive and nonzero
        logic due;     // a - b not negative
    } cmp_rsp_t;
endpackage
`default_nettype wire

// ===== src/pts_cmp.sv =====
// ----------------------------------------------------------------------------
// pts_cmp: shared wrap-around time compare unit.
// One 32-bit subtract whose sign and zero flags serve insert and wake walks.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_cmp
    import pts_pkg::*;
(
    input  wire cmp_req_t req,
    output cmp_rsp_t      rsp
);
    logic [TICK_W-1:0] diff;

    // Signed difference of two wrapping times.
    always_comb
    begin
        diff      = req.a - req.b;
        rsp.later = (diff != '0) && !diff[TICK_W-1];
        rsp.due   = !diff[TICK_W-1];
    end
endmodule
`default_nettype wire

// ===== src/priority_task_scheduler_with_delays.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays: bitmap priority scheduler with delays.
// Ready FIFOs per priority, a sorted delay list and a tick counter, all
// worked by a small sequencer around one shared time compare unit.
// ----------------------------------------------------------------------------
// Channel | Dir | Fields
// s_axis  | in  | tdata: op, task_id, priority_req, delay_ticks
// m_axis  | out | tdata: running_task, running_valid, woken_count, tick_now,
//         |     |        status
// A delay walks the sorted delay list (up to NUM_TASKS entries) through the
// shared compare unit. A tick wakes due tasks from the list head and pushes
// each onto its ready FIFO. A schedule requeues the running task, then scans
// the priority levels, most urgent first, for the first nonempty one.
// Reset clears all control state at once; there is no clearing pass.
// While a result waits on m_axis the block accepts no new item.
// ----------------------------------------------------------------------------
`default_nettype none
module priority_task_scheduler_with_delays
    import pts_pkg::*;
#(
    parameter int NUM_TASKS      = DEF_NUM_TASKS,
    parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], task_id[5:2], priority_req[10:6], delay_ticks[41:11], zero fill
    input  wire  [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // running_task[3:0], running_valid[4], woken_count[9:5], tick_now[41:10],
    // status[42], zero fill
    output logic [47:0] m_axis_tdata
);
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_PUSH  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_INSW  = 4'd4;
    localparam logic [3:0] S_WAKE  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_POP   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic [1:0] ret_reg;   // where to go after a push: out, wake, scan
    localparam logic [1:0] RET_OUT  = 2'd0;
    localparam logic [1:0] RET_WAKE = 2'd1;
    localparam logic [1:0] RET_SCAN = 2'd2;

    // Captured request.
    logic [1:0]        op_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [30:0]       ticks_reg;

    // Scheduler state.
    logic [NUM_PRIORITIES-1:0] bitmap_reg;
    logic [TW-1:0] ready_head [NUM_PRIORITIES];
    logic [TW-1:0] ready_tail [NUM_PRIORITIES];
    logic [TW-1:0] ready_link [NUM_TASKS];
    logic [TW-1:0] delay_link [NUM_TASKS];
    logic [TICK_W-1:0] wake_time [NUM_TASKS];
    logic [PW-1:0] task_level [NUM_TASKS];
    logic [1:0]    task_mode_reg [NUM_TASKS];
    logic [TW-1:0] delay_first_reg;
    logic          delay_empty_reg;
    logic [TW-1:0] cur_task_reg;
    logic          cur_valid_reg;
    logic [TICK_W-1:0] tick_reg;

    // Walk and result registers.
    logic [TW-1:0] push_t_reg;
    logic [TW-1:0] walk_cur_reg;
    logic [TW-1:0] walk_prev_reg;
    logic          have_prev_reg;
    logic [CW-1:0] walk_cnt_reg;
    logic [TICK_W-1:0] w_reg;
    logic [PW-1:0] scan_reg;
    logic [CW-1:0] woken_reg;
    logic          status_reg;

    cmp_req_t creq;
    cmp_rsp_t crsp;

    pts_cmp u_cmp (.req(creq), .rsp(crsp));

    // Shared compare operands depend on the walk in progress.
    always_comb
    begin
        if (state_reg == S_WAKE)
        begin
            creq.a = tick_reg;
            creq.b = wake_time[delay_first_reg];
        end
        else
        begin
            creq.a = wake_time[walk_cur_reg];
            creq.b = w_reg;
        end
    end

    logic [TID_W-1:0] in_tid;
    logic [PRI_W-1:0] in_pri;
    logic [PW-1:0]    pri_sat;
    logic [PW-1:0]    plv;
    logic             tid_ok;
    assign in_tid = s_axis_tdata[5:2];
    assign in_pri = s_axis_tdata[10:6];
    assign tid_ok = 32'(tid_reg) < NUM_TASKS;
    assign pri_sat = (32'(pri_reg) >= NUM_PRIORITIES) ? PW'(NUM_PRIORITIES - 1)
                                                      : PW'(pri_reg);
    assign plv = task_level[push_t_reg];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {5'd0, status_reg, tick_reg,
                            5'(woken_reg), cur_valid_reg,
                            cur_valid_reg ? 4'(cur_task_reg) : 4'd0};

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bitmap_reg      <= '0;
            delay_first_reg <= '0;
            delay_empty_reg <= 1'b1;
            cur_task_reg    <= '0;
            cur_valid_reg   <= 1'b0;
            tick_reg        <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
                task_mode_reg[i] <= MODE_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg     <= s_axis_tdata[1:0];
                        tid_reg    <= in_tid;
                        pri_reg    <= in_pri;
                        ticks_reg  <= s_axis_tdata[41:11];
                        woken_reg  <= '0;
                        status_reg <= 1'b0;
                        state_reg  <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    unique case (op_reg)
                        OP_MAKE_READY, OP_DELAY:
                        begin
                            if (!tid_ok)
                                state_reg <= S_OUT;
                            else if (task_mode_reg[TW'(tid_reg)] == MODE_READY ||
                                     task_mode_reg[TW'(tid_reg)] == MODE_DELAYED)
                            begin
                                status_reg <= 1'b1;
                                state_reg  <= S_OUT;
                            end
                            else if (op_reg == OP_MAKE_READY)
                            begin
                                task_level[TW'(tid_reg)] <= pri_sat;
                                push_t_reg <= TW'(tid_reg);
                                ret_reg    <= RET_OUT;
                                state_reg  <= S_PUSH;
                            end
                            else
                            begin
                                w_reg <= tick_reg + {1'b0, ticks_reg};
                                wake_time[TW'(tid_reg)] <= tick_reg + {1'b0, ticks_reg};
                                task_mode_reg[TW'(tid_reg)] <= MODE_DELAYED;
                                walk_cur_reg  <= delay_first_reg;
                                have_prev_reg <= 1'b0;
                                walk_cnt_reg  <= '0;
                                state_reg <= delay_empty_reg ? S_INSW : S_INS;
                            end
                        end
                        OP_TICK:
                        begin
                            tick_reg  <= tick_reg + 1'b1;
                            state_reg <= S_WAKE;
                        end
                        default:
                        begin
                            scan_reg <= '0;
                            if (cur_valid_reg && task_mode_reg[cur_task_reg] == MODE_RUNNING)
                            begin
                                push_t_reg <= cur_task_reg;
                                ret_reg    <= RET_SCAN;
                                state_reg  <= S_PUSH;
                            end
                            else
                                state_reg <= S_SCAN;
                            cur_valid_reg <= 1'b0;
                            cur_task_reg  <= '0;
                        end
                    endcase
                end
                S_PUSH:
                begin
                    if (bitmap_reg[plv])
                        ready_link[ready_tail[plv]] <= push_t_reg;
                    else
                        ready_head[plv] <= push_t_reg;
                    ready_tail[plv] <= push_t_reg;
                    bitmap_reg[plv] <= 1'b1;
                    task_mode_reg[push_t_reg] <= MODE_READY;
                    unique case (ret_reg)
                        RET_WAKE: state_reg <= S_WAKE;
                        RET_SCAN: state_reg <= S_SCAN;
                        default:  state_reg <= S_OUT;
                    endcase
                end
                S_INS:
                begin
                    // One list entry per cycle; stop at the first later one.
                    if (crsp.later)
                        state_reg <= S_INSW;
                    else
                    begin
                        walk_prev_reg <= walk_cur_reg;
                        have_prev_reg <= 1'b1;
                        walk_cnt_reg  <= walk_cnt_reg + 1'b1;
                        if (delay_link[walk_cur_reg] == walk_cur_reg ||
                            32'(walk_cnt_reg) + 1 >= NUM_TASKS)
                        begin
                            walk_cur_reg <= TW'(tid_reg);
                            state_reg    <= S_INSW;
                        end
                        else
                            walk_cur_reg <= delay_link[walk_cur_reg];
                    end
                end
                S_INSW:
                begin
                    // walk_cur is the successor, or the task itself at list end.
                    if (delay_empty_reg)
                        delay_link[TW'(tid_reg)] <= TW'(tid_reg);
                    else
                        delay_link[TW'(tid_reg)] <= walk_cur_reg;
                    if (have_prev_reg)
                        delay_link[walk_prev_reg] <= TW'(tid_reg);
                    else
                        delay_first_reg <= TW'(tid_reg);
                    delay_empty_reg <= 1'b0;
                    state_reg <= S_OUT;
                end
                S_WAKE:
                begin
                    if (!delay_empty_reg && 32'(woken_reg) < NUM_TASKS && crsp.due)
                    begin
                        if (delay_link[delay_first_reg] == delay_first_reg)
                            delay_empty_reg <= 1'b1;
                        else
                            delay_first_reg <= delay_link[delay_first_reg];
                        push_t_reg <= delay_first_reg;
                        woken_reg  <= woken_reg + 1'b1;
                        ret_reg    <= RET_WAKE;
                        state_reg  <= S_PUSH;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_SCAN:
                begin
                    // Most urgent level first: level 0 is scanned at once.
                    if (bitmap_reg[scan_reg])
                        state_reg <= S_POP;
                    else if (32'(scan_reg) == NUM_PRIORITIES - 1)
                        state_reg <= S_OUT;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_POP:
                begin
                    if (ready_tail[scan_reg] == ready_head[scan_reg])
                        bitmap_reg[scan_reg] <= 1'b0;
                    else
                        ready_head[scan_reg] <= ready_link[ready_head[scan_reg]];
                    task_mode_reg[ready_head[scan_reg]] <= MODE_RUNNING;
                    cur_task_reg  <= ready_head[scan_reg];
                    cur_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the scheduler.
// Watches the stream handshakes and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_checker
    import pts_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [47:0] s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);
    logic [1:0] last_op_reg;

    // Remember the operation of the transaction in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_op_reg <= OP_TICK;
        else if (s_axis_tvalid && s_axis_tready)
            last_op_reg <= s_axis_tdata[1:0];
    end

    // The block never takes an item while a result is waiting.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // An idle running slot reports task zero.
    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("task shown without valid");

    // Only ticks wake tasks.
    a_woken: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && last_op_reg != OP_TICK |-> m_axis_tdata[9:5] == 5'd0)
        else $error("tasks woken by a non-tick transaction");
endmodule

bind priority_task_scheduler_with_delays pts_checker u_pts_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
